/* src/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types, frame layout constants, fail codes and the CRC16 byte update
// used by the checked frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

  // Frame layout: head(2) command(1) payload(PAYLOAD_LEN) crc(2) tail(2)
  localparam int PAYLOAD_LEN = 168;

  localparam logic [7:0] POS_HEAD_LO   = 8'd0;
  localparam logic [7:0] POS_HEAD_HI   = 8'd1;
  localparam logic [7:0] POS_CMD       = 8'd2;
  localparam logic [7:0] POS_PAY_FIRST = 8'd3;
  localparam logic [7:0] POS_CRC_LO    = 8'(3 + PAYLOAD_LEN);
  localparam logic [7:0] POS_CRC_HI    = 8'(4 + PAYLOAD_LEN);
  localparam logic [7:0] POS_TAIL_LO   = 8'(5 + PAYLOAD_LEN);

  // CRC16 (Modbus)
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Verdict codes
  localparam logic [1:0] FAIL_NONE    = 2'd0;
  localparam logic [1:0] FAIL_SHORT   = 2'd1;
  localparam logic [1:0] FAIL_FRAMING = 2'd2;
  localparam logic [1:0] FAIL_CRC     = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_HEAD   = 2'd0;
  localparam logic [1:0] CFG_COMMAND_CODE = 2'd1;
  localparam logic [1:0] CFG_FRAME_TAIL   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       verdict_valid;
    logic       frame_ok;
    logic [1:0] fail_reason;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] frame_head;
    logic [7:0]  command_code;
    logic [15:0] frame_tail;
  } cfg_regs_t;

  // Fold one byte into the running CRC, LSB first
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/cfp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cfp_cfg_regs
// Configuration registers: expected head, command byte and tail.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_cfg_regs
  import cfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [15:0] wr_data,
  output cfg_regs_t        cfg
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  // Decode the write; an unused index leaves everything alone
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_FRAME_HEAD:   cfg_nxt.frame_head   = wr_data;
        CFG_COMMAND_CODE: cfg_nxt.command_code = wr_data[7:0];
        CFG_FRAME_TAIL:   cfg_nxt.frame_tail   = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* src/cfp_frame_core.sv */
// ----------------------------------------------------------------------------
// cfp_frame_core
// Frame tracker: byte position, running CRC and error flags. Produces one
// result per accepted beat and advances its state on that beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_frame_core
  import cfp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  cfg_regs_t      cfg,
  input  wire logic      accept,
  input  in_beat_t       beat,
  output out_beat_t      result
);

  logic [7:0]  pos_r,      pos_nxt;
  logic [15:0] crc_r,      crc_nxt;
  logic        ferr_r,     ferr_nxt;
  logic [7:0]  low_r,      low_nxt;
  logic [15:0] rcrc_r,     rcrc_nxt;
  logic        finished_r, finished_nxt;

  logic [7:0]  b;
  logic [15:0] crc_upd;

  assign b       = beat.data_byte;
  assign crc_upd = crc_add_byte(crc_r, b);

  // Classify the byte by position and build the result
  always_comb begin
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    ferr_nxt     = ferr_r;
    low_nxt      = low_r;
    rcrc_nxt     = rcrc_r;
    finished_nxt = finished_r;
    result       = '0;

    if (!finished_r) begin
      if (pos_r == POS_HEAD_LO) begin
        if (b != cfg.frame_head[7:0]) ferr_nxt = 1'b1;
        crc_nxt = crc_upd;
      end else if (pos_r == POS_HEAD_HI) begin
        if (b != cfg.frame_head[15:8]) ferr_nxt = 1'b1;
        crc_nxt = crc_upd;
      end else if (pos_r == POS_CMD) begin
        if (b != cfg.command_code) ferr_nxt = 1'b1;
        crc_nxt = crc_upd;
      end else if (pos_r >= POS_PAY_FIRST && pos_r < POS_CRC_LO) begin
        result.payload_byte  = b;
        result.payload_valid = 1'b1;
        crc_nxt = crc_upd;
      end else if (pos_r == POS_CRC_LO) begin
        low_nxt = b;
      end else if (pos_r == POS_CRC_HI) begin
        rcrc_nxt = {b, low_r};
      end else if (pos_r == POS_TAIL_LO) begin
        if (b != cfg.frame_tail[7:0]) ferr_nxt = 1'b1;
      end else begin
        // Final byte: give the frame verdict, framing beats CRC
        finished_nxt         = 1'b1;
        result.verdict_valid = 1'b1;
        if (ferr_r || b != cfg.frame_tail[15:8]) begin
          result.fail_reason = FAIL_FRAMING;
        end else if (crc_r != rcrc_r) begin
          result.fail_reason = FAIL_CRC;
        end else begin
          result.frame_ok    = 1'b1;
          result.fail_reason = FAIL_NONE;
        end
      end

      if (!finished_nxt) begin
        pos_nxt = pos_r + 8'd1;
      end

      // Buffer ended before the frame did
      if (beat.end_of_buffer && !finished_nxt) begin
        result.verdict_valid = 1'b1;
        result.frame_ok      = 1'b0;
        result.fail_reason   = FAIL_SHORT;
      end
    end

    // Drop all frame state at the end of the buffer
    if (beat.end_of_buffer) begin
      pos_nxt      = '0;
      crc_nxt      = CRC_INIT;
      ferr_nxt     = 1'b0;
      low_nxt      = '0;
      rcrc_nxt     = '0;
      finished_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      crc_r      <= CRC_INIT;
      ferr_r     <= 1'b0;
      low_r      <= '0;
      rcrc_r     <= '0;
      finished_r <= 1'b0;
    end else if (accept) begin
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      ferr_r     <= ferr_nxt;
      low_r      <= low_nxt;
      rcrc_r     <= rcrc_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/cfp_out_buf.sv */
// ----------------------------------------------------------------------------
// cfp_out_buf
// Two-entry result buffer. Keeps taking beats while one result waits, and
// asserts stall upstream only when both entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_out_buf
  import cfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  out_beat_t push_data,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_beat_t out_data
);

  logic [1:0] count_r, count_nxt;
  out_beat_t  slot0_r, slot0_nxt;
  out_beat_t  slot1_r, slot1_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_data  = slot0_r;

  // Advance the two slots
  always_comb begin
    count_nxt = count_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (push && pop) begin
      if (count_r == 2'd1) begin
        slot0_nxt = push_data;
      end else begin
        slot0_nxt = slot1_r;
        slot1_nxt = push_data;
      end
    end else if (pop) begin
      slot0_nxt = slot1_r;
      count_nxt = count_r - 2'd1;
    end else if (push) begin
      if (count_r == 2'd0) begin
        slot0_nxt = push_data;
      end else begin
        slot1_nxt = push_data;
      end
      count_nxt = count_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

`default_nettype wire

/* src/crc16_checked_frame_parser.sv */
// A result is registered in the two-entry result buffer and shows on
// out_valid once earlier results have left. Throughput: one byte per cycle
// unless the buffer is full; the CRC register has a combinational update.
// in_stall rises only when both result buffer entries are held by out_stall.
// Reset (rst_n low, synchronous) clears frame state, the CRC to 0xFFFF,
// the configuration registers and the result buffer.
// ----------------------------------------------------------------------------
// crc16_checked_frame_parser
// Byte-stream parser for a head/command/payload/CRC16/tail frame. Passes
// payload bytes through; verdict on last byte or an early buffer end.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_checked_frame_parser
  import cfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_beat_t        out_data,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_regs_t cfg;
  out_beat_t core_result;
  logic      in_accept;
  logic      buf_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  cfp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  cfp_frame_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .accept (in_accept),
    .beat   (in_data),
    .result (core_result)
  );

  cfp_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (core_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* src/cfp_checker.sv */
// ----------------------------------------------------------------------------
// cfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_checker
  import cfp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input in_beat_t       in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input out_beat_t      out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // No verdict means no ok flag and no fail code
  a_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.verdict_valid |->
      !out_data.frame_ok && out_data.fail_reason == FAIL_NONE)
    else $error("verdict fields set without verdict");

  // An ok frame carries a verdict with no fail code
  a_ok_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_ok |->
      out_data.verdict_valid && out_data.fail_reason == FAIL_NONE)
    else $error("ok frame with fail code");

  // A verdict that is not ok names a reason
  a_fail_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict_valid && !out_data.frame_ok |->
      out_data.fail_reason != FAIL_NONE)
    else $error("failed frame without reason");

  // A byte taken while the buffer is empty shows up next cycle, and a
  // payload byte passes through unchanged
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=>
      out_valid && (!out_data.payload_valid ||
                    out_data.payload_byte == $past(in_data.data_byte)))
    else $error("accepted byte not passed through");

endmodule

bind crc16_checked_frame_parser cfp_checker u_cfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
